@@ design/slrc_pkg.sv @@
package slrc_pkg;

   localparam int HISTORY_DEPTH_DEF = 2048;

   localparam int PRICE_W     = 32;
   localparam int TICK_W      = 16;
   localparam int WIN_W       = 11;
   localparam int SPREAD_W    = 24;
   localparam int COEF_W      = 32;
   localparam int SPREAD_FRAC = 8;
   localparam int COEF_FRAC   = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TICK_W-1:0] TICK_SIZE_RST     = TICK_W'(1);
   localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST = WIN_W'(120);

   // window sums and the wide numerator / denominator
   localparam int SUM_W  = SPREAD_W + WIN_W;
   localparam int SQ_W   = 2 * SPREAD_W;
   localparam int SSUM_W = SQ_W + WIN_W;
   localparam int WIDE_W = SSUM_W + WIN_W + 2;
   localparam int MCNT_W = $clog2(SUM_W + 1);

   localparam int DIV_NW = WIDE_W + COEF_FRAC;
   localparam int DIV_DW = WIDE_W;
   localparam int DCNT_W = $clog2(DIV_NW + 1);

   localparam logic [DIV_NW-1:0] SPREAD_POS_LIM =
      DIV_NW'((64'd1 << (SPREAD_W - 1)) - 64'd1);
   localparam logic [DIV_NW-1:0] SPREAD_NEG_LIM = DIV_NW'(64'd1 << (SPREAD_W - 1));
   localparam logic [DIV_NW-1:0] COEF_POS_LIM =
      DIV_NW'((64'd1 << (COEF_W - 1)) - 64'd1);
   localparam logic [DIV_NW-1:0] COEF_NEG_LIM = DIV_NW'(64'd1 << (COEF_W - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TICK_SIZE     = 1'b0,
      REG_WINDOW_LENGTH = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      MOP_M_SXY = 2'd0,
      MOP_SX_SY = 2'd1,
      MOP_M_SXX = 2'd2,
      MOP_SX_SX = 2'd3
   } mop_type;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_SPREAD = 11'b000_0000_0010,
      S_SWAIT  = 11'b000_0000_0100,
      S_STORE  = 11'b000_0000_1000,
      S_WALK   = 11'b000_0001_0000,
      S_MLOAD  = 11'b000_0010_0000,
      S_MRUN   = 11'b000_0100_0000,
      S_MDONE  = 11'b000_1000_0000,
      S_DLOAD  = 11'b001_0000_0000,
      S_DWAIT  = 11'b010_0000_0000,
      S_OUT    = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/slrc_if.sv @@
interface slrc_req_if import slrc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               bid_present;
   logic               ask_present;
   logic [PRICE_W-1:0] bid_price;
   logic [PRICE_W-1:0] ask_price;

   modport source (output valid, bid_present, ask_present, bid_price, ask_price,
                   input ready);
   modport sink (input valid, bid_present, ask_present, bid_price, ask_price,
                 output ready);
endinterface

interface slrc_rsp_if import slrc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coefficient;

   modport source (output valid, coefficient, input ready);
   modport sink (input valid, coefficient, output ready);
endinterface

interface slrc_csr_if import slrc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ design/spread_lag1_regression_coeff.sv @@
// Lag-one least-squares slope of the bid/ask spread over a sliding window.
// req_ch carries top-of-book updates; an update with either side absent is
// taken and changes nothing. Otherwise the spread in ticks
// (signed Q15.8) is written to a history ring, and once more than
// window_length spreads are stored, one slope (signed Q15.16) leaves on
// rsp_ch. csr_ch writes tick_size (index 0) and window_length (index 1);
// it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. An update with both sides present
// goes through the spread divide (skipped when tick_size is 0) and, when a
// result is due and window_length is at least 2, the walk over the history
// ring, one memory read per cycle, the 35-step shift-add multiplier run four
// times, and the 88-step shared divider run again for the slope.
// req_ch.ready is low while an update is worked on.
// The result sits in an output register: a stalled receiver holds it there
// while the next update is taken, and only a second finished result waits.
// Reset clears the state, empties the history and sets tick_size to 1 and
// window_length to 120.
module spread_lag1_regression_coeff import slrc_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   slrc_req_if.sink   req_ch,
   slrc_rsp_if.source rsp_ch,
   slrc_csr_if.sink   csr_ch
);
   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > WIN_W) ? FILL_W : WIN_W;
   localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(HISTORY_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(HISTORY_DEPTH);

   state_type state_ff, state_in;

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [ADDR_W-1:0] wslot_ff, wslot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic                       neg_ff, neg_in;
   logic [PRICE_W-1:0]         dmag_ff, dmag_in;
   logic signed [SPREAD_W-1:0] spread_ff, spread_in;

   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [WIN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              p0_valid_ff, p0_valid_in;
   logic              p0_first_ff, p0_first_in;
   logic              p0_last_ff, p0_last_in;
   logic signed [SPREAD_W-1:0] prev_ff, prev_in;
   logic              p1_valid_ff, p1_valid_in;
   logic              p1_x_ff, p1_x_in;
   logic              p1_y_ff, p1_y_in;
   logic              p1_last_ff, p1_last_in;
   logic signed [SPREAD_W-1:0] p1_val_ff, p1_val_in;
   logic signed [SQ_W-1:0]     p1_sq_ff, p1_sq_in;
   logic signed [SQ_W-1:0]     p1_xy_ff, p1_xy_in;
   logic signed [SUM_W-1:0]    sx_ff, sx_in;
   logic signed [SUM_W-1:0]    sy_ff, sy_in;
   logic signed [SSUM_W-1:0]   sxx_ff, sxx_in;
   logic signed [SSUM_W-1:0]   sxy_ff, sxy_in;

   mop_type            mop_ff, mop_in;
   logic [WIDE_W-1:0]  ma_ff, ma_in;
   logic [SUM_W-1:0]   mb_ff, mb_in;
   logic [WIDE_W-1:0]  macc_ff, macc_in;
   logic [MCNT_W-1:0]  mcnt_ff, mcnt_in;
   logic               msign_ff, msign_in;
   logic [WIDE_W-1:0]  num_ff, num_in;
   logic [WIDE_W-1:0]  den_ff, den_in;

   logic [COEF_W-1:0]  coef_ff, coef_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COEF_W-1:0]  rsp_coef_ff, rsp_coef_in;

   logic                       req_xfer;
   logic                       crossed;
   logic [FILL_W-1:0]          fill_next;
   logic                       ram_we;
   logic signed [SPREAD_W-1:0] ram_rdata;
   logic [WIN_W-1:0]           m_val;
   logic signed [WIDE_W-1:0]   a_sel;
   logic signed [SUM_W-1:0]    b_sel;
   logic                       mop_sub;
   logic [WIDE_W-1:0]          mop_base;
   logic [WIDE_W-1:0]          mres;
   logic [WIDE_W-1:0]          num_mag;
   logic [WIDE_W-1:0]          den_mag;
   logic [DIV_NW-1:0]          quo;
   logic [SPREAD_W-1:0]        spread_q;
   logic [COEF_W-1:0]          coef_q;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign crossed      = req_ch.ask_price < req_ch.bid_price;
   assign fill_next    = (fill_ff == FULL_COUNT) ? fill_ff : fill_ff + FILL_W'(1);
   assign m_val        = win_ff - WIN_W'(1);
   assign num_mag      = num_ff[WIDE_W-1] ? -num_ff : num_ff;
   assign den_mag      = den_ff[WIDE_W-1] ? -den_ff : den_ff;
   assign quo          = div_rsp.quotient;

   // saturate the divider's magnitude to the signed result formats
   always_comb begin
      if (!neg_ff) begin
         spread_q = (quo > SPREAD_POS_LIM) ? SPREAD_POS_LIM[SPREAD_W-1:0]
                                           : quo[SPREAD_W-1:0];
         coef_q   = (quo > COEF_POS_LIM) ? COEF_POS_LIM[COEF_W-1:0] : quo[COEF_W-1:0];
      end else begin
         spread_q = (quo > SPREAD_NEG_LIM) ? SPREAD_NEG_LIM[SPREAD_W-1:0]
                                           : -quo[SPREAD_W-1:0];
         coef_q   = (quo > COEF_NEG_LIM) ? COEF_NEG_LIM[COEF_W-1:0] : -quo[COEF_W-1:0];
      end
   end

   // operand select for the shift-add multiplier
   always_comb begin
      case (mop_ff)
         MOP_M_SXY: begin
            a_sel = WIDE_W'(sxy_ff);
            b_sel = $signed(SUM_W'(m_val));
         end
         MOP_SX_SY: begin
            a_sel = WIDE_W'(sy_ff);
            b_sel = sx_ff;
         end
         MOP_M_SXX: begin
            a_sel = WIDE_W'(sxx_ff);
            b_sel = $signed(SUM_W'(m_val));
         end
         MOP_SX_SX: begin
            a_sel = WIDE_W'(sx_ff);
            b_sel = sx_ff;
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
      mop_sub  = (mop_ff == MOP_SX_SY) || (mop_ff == MOP_SX_SX);
      mop_base = (mop_ff == MOP_SX_SY) ? num_ff :
                 (mop_ff == MOP_SX_SX) ? den_ff : '0;
      mres     = (msign_ff ^ mop_sub) ? mop_base - macc_ff : mop_base + macc_ff;
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      win_in       = win_ff;
      wslot_in     = wslot_ff;
      fill_in      = fill_ff;
      neg_in       = neg_ff;
      dmag_in      = dmag_ff;
      spread_in    = spread_ff;
      rd_addr_in   = rd_addr_ff;
      rd_cnt_in    = rd_cnt_ff;
      p0_valid_in  = 1'b0;
      p0_first_in  = p0_first_ff;
      p0_last_in   = p0_last_ff;
      prev_in      = prev_ff;
      p1_valid_in  = p0_valid_ff;
      p1_x_in      = !p0_first_ff;
      p1_y_in      = !p0_last_ff;
      p1_last_in   = p0_last_ff;
      p1_val_in    = ram_rdata;
      p1_sq_in     = ram_rdata * ram_rdata;
      p1_xy_in     = ram_rdata * prev_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      mop_in       = mop_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      macc_in      = macc_ff;
      mcnt_in      = mcnt_ff;
      msign_in     = msign_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      coef_in      = coef_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_coef_in  = rsp_coef_ff;
      ram_we       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_NW'({dmag_ff, {SPREAD_FRAC{1'b0}}});
      div_req.divisor  = DIV_DW'(tick_ff);

      if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            REG_TICK_SIZE:     tick_in = csr_ch.wdata[TICK_W-1:0];
            REG_WINDOW_LENGTH: win_in  = csr_ch.wdata[WIN_W-1:0];
            default: begin
            end
         endcase
      end

      if (p0_valid_ff) begin
         prev_in = ram_rdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_ch.bid_present && req_ch.ask_present) begin
               neg_in   = crossed;
               dmag_in  = crossed ? req_ch.bid_price - req_ch.ask_price
                                  : req_ch.ask_price - req_ch.bid_price;
               state_in = S_SPREAD;
            end
         end
         S_SPREAD: begin
            if (tick_ff == '0) begin
               spread_in = '0;
               state_in  = S_STORE;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (div_rsp.done) begin
               spread_in = spread_q;
               state_in  = S_STORE;
            end
         end
         S_STORE: begin
            ram_we   = 1'b1;
            wslot_in = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + ADDR_W'(1);
            fill_in  = fill_next;
            if (CMP_W'(fill_next) <= CMP_W'(win_ff)) begin
               state_in = S_IDLE;
            end else if (win_ff < WIN_W'(2)) begin
               coef_in  = '0;
               state_in = S_OUT;
            end else begin
               rd_addr_in = wslot_ff;
               rd_cnt_in  = '0;
               sx_in      = '0;
               sy_in      = '0;
               sxx_in     = '0;
               sxy_in     = '0;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            // newest spread first; x is one age older than y
            if (rd_cnt_ff != win_ff) begin
               p0_valid_in = 1'b1;
               p0_first_in = (rd_cnt_ff == '0);
               p0_last_in  = (rd_cnt_ff == win_ff - WIN_W'(1));
               rd_cnt_in   = rd_cnt_ff + WIN_W'(1);
               rd_addr_in  = (rd_addr_ff == '0) ? LAST_SLOT : rd_addr_ff - ADDR_W'(1);
            end
            if (p1_valid_ff) begin
               if (p1_x_ff) begin
                  sx_in  = sx_ff + SUM_W'(p1_val_ff);
                  sxx_in = sxx_ff + SSUM_W'(p1_sq_ff);
                  sxy_in = sxy_ff + SSUM_W'(p1_xy_ff);
               end
               if (p1_y_ff) begin
                  sy_in = sy_ff + SUM_W'(p1_val_ff);
               end
               if (p1_last_ff) begin
                  mop_in   = MOP_M_SXY;
                  state_in = S_MLOAD;
               end
            end
         end
         S_MLOAD: begin
            ma_in    = a_sel[WIDE_W-1] ? -a_sel : a_sel;
            mb_in    = b_sel[SUM_W-1] ? -b_sel : b_sel;
            msign_in = a_sel[WIDE_W-1] ^ b_sel[SUM_W-1];
            macc_in  = '0;
            mcnt_in  = MCNT_W'(SUM_W);
            state_in = S_MRUN;
         end
         S_MRUN: begin
            if (mb_ff[0]) begin
               macc_in = macc_ff + ma_ff;
            end
            ma_in   = ma_ff << 1;
            mb_in   = mb_ff >> 1;
            mcnt_in = mcnt_ff - MCNT_W'(1);
            if (mcnt_ff == MCNT_W'(1)) begin
               state_in = S_MDONE;
            end
         end
         S_MDONE: begin
            if ((mop_ff == MOP_M_SXY) || (mop_ff == MOP_SX_SY)) begin
               num_in = mres;
            end else begin
               den_in = mres;
            end
            if (mop_ff == MOP_SX_SX) begin
               state_in = S_DLOAD;
            end else begin
               mop_in   = mop_type'(mop_ff + 2'd1);
               state_in = S_MLOAD;
            end
         end
         S_DLOAD: begin
            if (den_ff == '0) begin
               coef_in  = '0;
               state_in = S_OUT;
            end else begin
               neg_in           = num_ff[WIDE_W-1] ^ den_ff[WIDE_W-1];
               div_req.start    = 1'b1;
               div_req.dividend = {num_mag, {COEF_FRAC{1'b0}}};
               div_req.divisor  = den_mag;
               state_in         = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (div_rsp.done) begin
               coef_in  = coef_q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = coef_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= TICK_SIZE_RST;
         win_ff       <= WINDOW_LENGTH_RST;
         wslot_ff     <= '0;
         fill_ff      <= '0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         win_ff       <= win_in;
         wslot_ff     <= wslot_in;
         fill_ff      <= fill_in;
         p0_valid_ff  <= p0_valid_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      dmag_ff     <= dmag_in;
      spread_ff   <= spread_in;
      rd_addr_ff  <= rd_addr_in;
      rd_cnt_ff   <= rd_cnt_in;
      p0_first_ff <= p0_first_in;
      p0_last_ff  <= p0_last_in;
      prev_ff     <= prev_in;
      p1_x_ff     <= p1_x_in;
      p1_y_ff     <= p1_y_in;
      p1_last_ff  <= p1_last_in;
      p1_val_ff   <= p1_val_in;
      p1_sq_ff    <= p1_sq_in;
      p1_xy_ff    <= p1_xy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sxx_ff      <= sxx_in;
      sxy_ff      <= sxy_in;
      mop_ff      <= mop_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      macc_ff     <= macc_in;
      mcnt_ff     <= mcnt_in;
      msign_ff    <= msign_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      coef_ff     <= coef_in;
      rsp_coef_ff <= rsp_coef_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.coefficient = rsp_coef_ff;

   slrc_ram #(
      .WIDTH (SPREAD_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wslot_ff),
      .wr_data (spread_ff),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   slrc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );
endmodule

@@ design/slrc_ram.sv @@
module slrc_ram import slrc_pkg::*; #(
   parameter int WIDTH = SPREAD_W,
   parameter int DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/slrc_div.sv @@
module slrc_div import slrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dsr_ff, dsr_in;
   logic [DIV_DW:0]   shifted;
   logic [DIV_DW+1:0] trial;

   // restoring divide, one quotient bit per cycle; dividend bits leave the top
   // of quo_ff while quotient bits enter at the bottom
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_NW);
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - DCNT_W'(1);
         if (!trial[DIV_DW+1]) begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

@@ design/slrc_checker.sv @@
module slrc_checker import slrc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_bid_present,
   input logic              req_ask_present,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COEF_W-1:0] rsp_coefficient
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_coefficient))
      else $error("stalled result changed");

   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_bid_present && req_ask_present |=> !req_ready)
      else $error("ready right after a two-sided update");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result in the cycle after an input transfer");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind spread_lag1_regression_coeff slrc_checker u_slrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_bid_present (req_ch.bid_present),
   .req_ask_present (req_ch.ask_present),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_coefficient (rsp_ch.coefficient)
);

@@ bench/spread_lag1_regression_coeff_tb.sv @@
module spread_lag1_regression_coeff_tb;
   import slrc_pkg::*;

   localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
   localparam int RANDOM_UPDATES = 230;
   localparam int SETTLE_CYCLES  = 400;
   localparam int QUIET_LIMIT    = 20000;

   localparam logic signed [127:0] COEF_MAX = 128'sd2147483647;
   localparam logic signed [127:0] COEF_MIN = -128'sd2147483648;

   typedef struct {
      logic               bid_present;
      logic               ask_present;
      logic [PRICE_W-1:0] bid_price;
      logic [PRICE_W-1:0] ask_price;
      bit                 hold_for_results;
   } book_update_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slrc_req_if req_ch ();
   slrc_rsp_if rsp_ch ();
   slrc_csr_if csr_ch ();

   spread_lag1_regression_coeff dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // book updates waiting to be sent and coefficients waiting to arrive
   book_update_t             book_updates[$];
   logic signed [COEF_W-1:0] expected_coefs[$];

   // predicted block state
   logic signed [SPREAD_W-1:0] spread_ring [HIST_DEPTH];
   int unsigned                ring_fill  = 0;
   int unsigned                ring_slot  = 0;
   int unsigned                ring_wraps = 0;
   logic [TICK_W-1:0]          tick_cfg   = TICK_SIZE_RST;
   logic [WIN_W-1:0]           window_cfg = WINDOW_LENGTH_RST;

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int          walk_ticks        = 0;
   int unsigned quiet_cycles      = 0;
   int unsigned mismatches        = 0;
   int unsigned updates_taken     = 0;
   int unsigned updates_one_sided = 0;
   int unsigned coefs_compared    = 0;

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.bid_present = 1'b0;
      req_ch.ask_present = 1'b0;
      req_ch.bid_price   = '0;
      req_ch.ask_price   = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = REG_TICK_SIZE;
      csr_ch.wdata       = '0;
   end

   task automatic report_mismatch(string what);
      mismatches++;
      $display("mismatch after %0d updates: %s", updates_taken, what);
   endtask

   function automatic logic signed [SPREAD_W-1:0] spread_ticks(logic [PRICE_W-1:0] bid,
                                                               logic [PRICE_W-1:0] ask);
      longint diff;
      longint quot;
      if (tick_cfg == '0)
         return '0;
      diff = $signed({32'd0, ask}) - $signed({32'd0, bid});
      quot = (diff * 256) / $signed({48'd0, tick_cfg});
      if (quot > 8388607)
         quot = 8388607;
      else if (quot < -8388608)
         quot = -8388608;
      return quot[SPREAD_W-1:0];
   endfunction

   function automatic logic signed [COEF_W-1:0] lag1_slope(int unsigned w);
      logic signed [127:0] sx, sy, sxx, sxy, m, x, y, num, den, quot;
      if (w <= 1)
         return '0;
      sx  = 0;
      sy  = 0;
      sxx = 0;
      sxy = 0;
      m   = w - 1;
      for (int unsigned k = 0; k + 1 < w; k++) begin
         y = spread_ring[(ring_slot + HIST_DEPTH - 1 - k) % HIST_DEPTH];
         x = spread_ring[(ring_slot + HIST_DEPTH - 2 - k) % HIST_DEPTH];
         sx  += x;
         sy  += y;
         sxx += x * x;
         sxy += x * y;
      end
      num = m * sxy - sx * sy;
      den = m * sxx - sx * sx;
      if (den == 0)
         return '0;
      quot = (num * 128'sd65536) / den;
      if (quot > COEF_MAX)
         quot = COEF_MAX;
      else if (quot < COEF_MIN)
         quot = COEF_MIN;
      return quot[COEF_W-1:0];
   endfunction

   function automatic void predict_book_update(book_update_t u);
      if (!u.bid_present || !u.ask_present) begin
         updates_one_sided++;
         return;
      end
      spread_ring[ring_slot] = spread_ticks(u.bid_price, u.ask_price);
      ring_slot = (ring_slot + 1) % HIST_DEPTH;
      if (ring_slot == 0)
         ring_wraps++;
      if (ring_fill < HIST_DEPTH)
         ring_fill++;
      if (ring_fill > window_cfg)
         expected_coefs.push_back(lag1_slope(window_cfg));
   endfunction

   // driver: one update per transfer, optional pause until all coefficients are back
   always @(posedge clock) begin : feed_updates
      book_update_t next;
      logic         req_xfer;
      logic         rsp_xfer;
      req_xfer = req_ch.valid && req_ch.ready;
      rsp_xfer = rsp_ch.valid && rsp_ch.ready;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (book_updates.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
             !(book_updates[0].hold_for_results &&
               (expected_coefs.size() != 0 || req_xfer || rsp_xfer))) begin
            next = book_updates.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.bid_present <= next.bid_present;
            req_ch.ask_present <= next.ask_present;
            req_ch.bid_price   <= next.bid_price;
            req_ch.ask_price   <= next.ask_price;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: compare coefficients, then predict from the accepted update
   always @(posedge clock) begin : check_coefs
      book_update_t             seen;
      logic signed [COEF_W-1:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= $urandom_range(99) >= receiver_idle_pct;
         if (rsp_ch.valid && rsp_ch.ready) begin
            coefs_compared++;
            if (expected_coefs.size() == 0) begin
               report_mismatch($sformatf("coefficient %0d with none expected",
                                         rsp_ch.coefficient));
            end else begin
               want = expected_coefs.pop_front();
               if (rsp_ch.coefficient !== want)
                  report_mismatch($sformatf("coefficient %0d, expected %0d",
                                            rsp_ch.coefficient, want));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            updates_taken++;
            seen.bid_present      = req_ch.bid_present;
            seen.ask_present      = req_ch.ask_present;
            seen.bid_price        = req_ch.bid_price;
            seen.ask_price        = req_ch.ask_price;
            seen.hold_for_results = 1'b0;
            predict_book_update(seen);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         REG_TICK_SIZE: tick_cfg = value[TICK_W-1:0];
         default:       window_cfg = value[WIN_W-1:0];
      endcase
      @(negedge clock);
   endtask

   // unused upper data bits get random values
   task automatic set_window(int unsigned w);
      logic [CSR_DATA_W-1:0] value;
      value = CSR_DATA_W'($urandom);
      value[WIN_W-1:0] = w[WIN_W-1:0];
      write_reg(REG_WINDOW_LENGTH, value);
   endtask

   task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   function automatic void queue_update(logic bp, logic ap, logic [PRICE_W-1:0] bid,
                                        logic [PRICE_W-1:0] ask, bit hold = 1'b0);
      book_update_t u;
      u.bid_present      = bp;
      u.ask_present      = ap;
      u.bid_price        = bid;
      u.ask_price        = ask;
      u.hold_for_results = hold;
      book_updates.push_back(u);
   endfunction

   // mostly a mean-reverting spread walk, some raw prices, crossed books and one-sided noise
   function automatic void queue_random_updates(int unsigned count);
      int unsigned        taken;
      int unsigned        pick;
      logic [PRICE_W-1:0] bid;
      logic [PRICE_W-1:0] ask;
      taken = 0;
      while (taken < count) begin
         pick = $urandom_range(99);
         bid  = $urandom;
         ask  = $urandom;
         if (pick < 6) begin
            case ($urandom_range(2))
               0:       queue_update(1'b0, 1'b1, bid, ask);
               1:       queue_update(1'b1, 1'b0, bid, ask);
               default: queue_update(1'b0, 1'b0, bid, ask);
            endcase
         end else begin
            if (pick >= 14 && pick < 18) begin
               ask = bid - PRICE_W'($urandom_range(3));
            end else if (pick >= 18) begin
               walk_ticks = walk_ticks * 3 / 4 + int'($urandom_range(40)) - 16;
               bid = PRICE_W'($urandom_range(32'h7000_0000, 32'h4000_0000));
               ask = bid + PRICE_W'(walk_ticks * int'(tick_cfg) +
                                    int'($urandom_range(tick_cfg)));
            end
            queue_update(1'b1, 1'b1, bid, ask, $urandom_range(99) < 4);
            taken++;
         end
      end
   endfunction

   task automatic drain_and_settle();
      do @(negedge clock);
      while (book_updates.size() != 0 || req_ch.valid || expected_coefs.size() != 0);
      repeat (int'(window_cfg) + SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : run_test
      int unsigned       random_taken;
      int unsigned       win_pick;
      int unsigned       batch;
      logic [TICK_W-1:0] tick_pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_idling(9, 84);

      // tick of 256 makes the raw Q15.8 spread equal to the price difference
      write_reg(REG_TICK_SIZE, 16'd256);
      set_window(3);
      queue_update(1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_update(1'b1, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_update(1'b0, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      queue_update(1'b1, 1'b1, 32'd1000, 32'd1007);
      queue_update(1'b1, 1'b1, 32'd1000, 32'd1000);
      queue_update(1'b1, 1'b1, 32'd1000, 32'd1001);
      queue_update(1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_update(1'b1, 1'b1, 32'd77, 32'd77);
      queue_update(1'b1, 1'b1, 32'd77, 32'd78);
      queue_update(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_update(1'b1, 1'b1, 32'd100, 32'd90, 1'b1);
      repeat (3) queue_update(1'b1, 1'b1, 32'd500, 32'd505);
      drain_and_settle();

      write_reg(REG_TICK_SIZE, 16'd0);
      set_window(1);
      queue_update(1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_update(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_update(1'b1, 1'b1, 32'd12345, 32'd999);
      drain_and_settle();

      write_reg(REG_TICK_SIZE, 16'hFFFF);
      set_window(2);
      queue_update(1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_update(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_update(1'b1, 1'b1, 32'd0, 32'd1000000);
      drain_and_settle();

      // negative quotients truncate toward zero
      write_reg(REG_TICK_SIZE, 16'd3);
      set_window(4);
      queue_update(1'b1, 1'b1, 32'd10, 32'd9);
      queue_update(1'b1, 1'b1, 32'd9, 32'd10);
      queue_update(1'b1, 1'b1, 32'd20, 32'd22);
      queue_update(1'b1, 1'b1, 32'd22, 32'd20);
      queue_update(1'b1, 1'b1, 32'd40, 32'd47);
      drain_and_settle();

      set_idling(84, 9);
      random_taken = 0;
      while (random_taken < RANDOM_UPDATES) begin
         if (random_taken >= RANDOM_UPDATES / 2)
            set_idling(0, 0);
         case ($urandom_range(4))
            0:       tick_pick = '0;
            1:       tick_pick = 16'd1;
            2:       tick_pick = 16'hFFFF;
            3:       tick_pick = TICK_W'($urandom_range(300, 2));
            default: tick_pick = TICK_W'($urandom);
         endcase
         case ($urandom_range(9))
            0:       win_pick = 1;
            1:       win_pick = 2047;
            2:       win_pick = $urandom_range(600, 100);
            default: win_pick = $urandom_range(40, 2);
         endcase
         write_reg(REG_TICK_SIZE, tick_pick);
         set_window(win_pick);
         batch = (win_pick >= 100) ? 4 : $urandom_range(35, 15);
         queue_random_updates(batch);
         random_taken += batch;
         drain_and_settle();
      end

      $display("%0d book updates taken (%0d one-sided), %0d coefficients compared",
               updates_taken, updates_one_sided, coefs_compared);
      $display("tick sizes 0 to 65535, windows 1 to 2047, history ring wrapped %0d times",
               ring_wraps);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
